@@ src/rst_pkg.sv @@
package rst_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_WRAP_ENABLE      = 2'd0;
	localparam logic [1:0] REG_CENTER_TOLERANCE = 2'd1;
	localparam logic [1:0] REG_WIDTH_TOLERANCE  = 2'd2;

	localparam int        TOL_W          = 10;
	localparam logic [9:0] CENTER_TOL_RST = 10'd40;
	localparam logic [9:0] WIDTH_TOL_RST  = 10'd10;

	typedef struct packed {
		logic [TOL_W-1:0] center;
		logic [TOL_W-1:0] width;
	} tol_t;

	typedef enum logic [2:0] {
		S_PIX,
		S_LOAD,
		S_WAIT,
		S_EMIT,
		S_EMPTY,
		S_COMMIT
	} state_t;

endpackage

@@ src/rst_if.sv @@
interface rst_pix_if;
	logic valid;
	logic ready;
	logic pixel_on;
	logic row_end;
	modport source (output valid, pixel_on, row_end, input ready);
	modport sink (input valid, pixel_on, row_end, output ready);
endinterface

interface rst_seg_if #(parameter int COL_W = 10, parameter int ID_BITS = 16);
	logic             valid;
	logic             ready;
	logic             segment_valid;
	logic [COL_W-1:0] seg_start;
	logic [COL_W:0]   seg_end;
	logic [COL_W:0]   seg_center;
	logic [COL_W:0]   seg_width;
	logic [ID_BITS-1:0] track_id;
	logic             overflow;
	logic             last_of_row;
	modport source (output valid, segment_valid, seg_start, seg_end, seg_center, seg_width,
		track_id, overflow, last_of_row, input ready);
	modport sink (input valid, segment_valid, seg_start, seg_end, seg_center, seg_width,
		track_id, overflow, last_of_row, output ready);
endinterface

interface rst_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [9:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/rst_cell.sv @@
module rst_cell import rst_pkg::*; #(
	parameter int COL_W   = 10,
	parameter int ID_BITS = 16,
	parameter int CNT_W   = 5,
	parameter int IDX_W   = 4,
	parameter int IDX     = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tol_t               tol,
	input  logic [CNT_W-1:0]   old_count,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_idx,
	input  logic [ID_BITS-1:0] wr_id,
	input  logic [COL_W:0]     wr_c,
	input  logic [COL_W:0]     wr_w,
	input  logic               commit,
	input  logic               lv_i,
	input  logic [COL_W:0]     lc_i,
	input  logic [COL_W:0]     lw_i,
	input  logic [ID_BITS-1:0] lid_i,
	output logic               lv_o,
	output logic [COL_W:0]     lc_o,
	output logic [COL_W:0]     lw_o,
	output logic [ID_BITS-1:0] lid_o
);

	logic [ID_BITS-1:0] old_id_q, nxt_id_q;
	logic [COL_W:0]     old_c_q, old_w_q, nxt_c_q, nxt_w_q;
	logic [COL_W:0]     dc, dw;
	logic               live, hit;

	// Compare the passing run against the old run held here
	always_comb begin
		dc   = (lc_i > old_c_q) ? lc_i - old_c_q : old_c_q - lc_i;
		dw   = (lw_i > old_w_q) ? lw_i - old_w_q : old_w_q - lw_i;
		live = CNT_W'(IDX) < old_count;
		hit  = live && (dc < (COL_W+1)'(tol.center)) && (dw < (COL_W+1)'(tol.width));
	end

	// Hold old and fresh entries; promote fresh at row commit
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == IDX_W'(IDX)) begin
			nxt_id_q <= wr_id;
			nxt_c_q  <= wr_c;
			nxt_w_q  <= wr_w;
		end
		if (commit) begin
			old_id_q <= nxt_id_q;
			old_c_q  <= nxt_c_q;
			old_w_q  <= nxt_w_q;
		end
	end

	// Advance the request to the neighbor, later hits override
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_o <= 1'b0;
		end else begin
			lv_o <= lv_i;
		end
	end

	always_ff @(posedge clk) begin
		lc_o  <= lc_i;
		lw_o  <= lw_i;
		lid_o <= hit ? old_id_q : lid_i;
	end

endmodule

@@ src/binary_row_segment_tracker.sv @@
// Pixels: one request per cycle while a row is streaming; input is held off at row end.
// Row end: each run passes a chain of MAX_SEGMENTS match cells in the LOAD, WAIT and EMIT states
// (output stalls hold EMIT), then the COMMIT state; an empty row goes through EMPTY and COMMIT.
// The match chain length sets the per-run time.
// Reset clears counters, ids, state and config registers; run and match tables hold garbage
// until written and are never read before then.
module binary_row_segment_tracker import rst_pkg::*; #(
	parameter int ROW_PIXELS_MAX = 1024,
	parameter int MAX_SEGMENTS   = 16,
	parameter int ID_BITS        = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	rst_pix_if.sink pix,
	rst_seg_if.source seg,
	rst_cfg_if.sink cfg
);

	localparam int COL_W = $clog2(ROW_PIXELS_MAX);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

	state_t state_q, state_d;

	logic               wrap_q;
	tol_t               tol_q;
	logic [COL_W-1:0]   col_q, rs_q;
	logic               prev_q, ovf_q;
	logic [CNT_W-1:0]   cnt_q, old_cnt_q;
	logic [IDX_W-1:0]   k_q;
	logic [ID_BITS-1:0] hid_q, found_q;
	logic [COL_W-1:0]   tab_s_q [MAX_SEGMENTS];
	logic [COL_W:0]     tab_e_q [MAX_SEGMENTS];
	logic [COL_W-1:0]   qs_q;
	logic [COL_W:0]     qe_q, qc_q, qw_q;

	logic               ov_q, osv_q, oovf_q, olast_q;
	logic [COL_W-1:0]   os_q;
	logic [COL_W:0]     oe_q, oc_q, ow_q;
	logic [ID_BITS-1:0] oid_q;

	// Chain links
	logic               lv  [MAX_SEGMENTS+1];
	logic [COL_W:0]     lc  [MAX_SEGMENTS+1];
	logic [COL_W:0]     lw  [MAX_SEGMENTS+1];
	logic [ID_BITS-1:0] lid [MAX_SEGMENTS+1];

	logic pix_fire, in_rdy, q_fire, emit, empty_emit, commit, ofree;
	logic fall, rise, done, trail, wrapj, push, full;
	logic [COL_W-1:0] rs_eff, push_s;
	logic [COL_W:0]   push_e;
	logic [CNT_W-1:0] cnt_nxt;
	logic [COL_W-1:0] ks;
	logic [COL_W:0]   ke, kc, kw;
	logic [COL_W+1:0] ksum;
	logic [ID_BITS-1:0] id_new, id_sel;
	logic             is_last;

	assign cfg.ready = 1'b1;
	assign pix.ready = in_rdy;
	assign pix_fire  = pix.valid && in_rdy;
	assign ofree     = !ov_q || seg.ready;

	// Run detection for the current pixel
	always_comb begin
		fall    = !pix.pixel_on && prev_q;
		rise    = pix.pixel_on && !prev_q;
		rs_eff  = rise ? col_q : rs_q;
		done    = pix.row_end || (col_q == COL_W'(ROW_PIXELS_MAX - 1));
		trail   = done && pix.pixel_on;
		wrapj   = trail && wrap_q && (cnt_q != '0) && (tab_s_q[0] == '0);
		push    = fall || (trail && !wrapj);
		push_s  = fall ? rs_q : rs_eff;
		push_e  = fall ? {1'b0, col_q} - 1'b1 : {1'b0, col_q};
		full    = cnt_q == CNT_W'(MAX_SEGMENTS);
		cnt_nxt = cnt_q + CNT_W'(push && !full);
	end

	// Query for run k; keep the carry of start plus end
	always_comb begin
		ks   = tab_s_q[k_q];
		ke   = tab_e_q[k_q];
		kw   = ke - {1'b0, ks};
		ksum = {1'b0, ke} + {2'b00, ks};
		kc   = ksum[COL_W+1:1];
	end

	always_comb begin
		id_new  = (hid_q == ID_MAX) ? ID_BITS'(1) : hid_q + 1'b1;
		id_sel  = (found_q != '0) ? found_q : id_new;
		is_last = (CNT_W'(k_q) + 1'b1) == cnt_q;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_PIX: begin
				if (pix.valid && done) state_d = (cnt_nxt == '0) ? S_EMPTY : S_LOAD;
			end
			S_LOAD: state_d = S_WAIT;
			S_WAIT: begin
				if (lv[MAX_SEGMENTS]) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (ofree) state_d = is_last ? S_COMMIT : S_LOAD;
			end
			S_EMPTY: begin
				if (ofree) state_d = S_COMMIT;
			end
			S_COMMIT: state_d = S_PIX;
			default: state_d = S_PIX;
		endcase
	end

	// Control outputs
	always_comb begin
		in_rdy     = 1'b0;
		q_fire     = 1'b0;
		emit       = 1'b0;
		empty_emit = 1'b0;
		commit     = 1'b0;
		unique case (state_q)
			S_PIX:    in_rdy = 1'b1;
			S_LOAD:   q_fire = 1'b1;
			S_WAIT:   ;
			S_EMIT:   emit = ofree;
			S_EMPTY:  empty_emit = ofree;
			S_COMMIT: commit = 1'b1;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_PIX;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q       <= 1'b0;
			tol_q.center <= CENTER_TOL_RST;
			tol_q.width  <= WIDTH_TOL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WRAP_ENABLE:      wrap_q <= cfg.data[0];
				REG_CENTER_TOLERANCE: tol_q.center <= cfg.data;
				REG_WIDTH_TOLERANCE:  tol_q.width <= cfg.data;
				default:              ;
			endcase
		end
	end

	// Row scan and run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			prev_q    <= 1'b0;
			rs_q      <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			old_cnt_q <= '0;
			k_q       <= '0;
			hid_q     <= '0;
		end else begin
			if (pix_fire) begin
				if (push && full) ovf_q <= 1'b1;
				cnt_q <= cnt_nxt;
				k_q   <= '0;
				if (done) begin
					col_q  <= '0;
					prev_q <= 1'b0;
					rs_q   <= '0;
				end else begin
					col_q  <= col_q + 1'b1;
					prev_q <= pix.pixel_on;
					rs_q   <= rs_eff;
				end
			end
			if (emit) begin
				k_q <= k_q + 1'b1;
				if (found_q == '0) hid_q <= id_new;
			end
			if (commit) begin
				old_cnt_q <= cnt_q;
				cnt_q     <= '0;
				ovf_q     <= 1'b0;
			end
		end
	end

	// Run table writes, query latch and match result capture
	always_ff @(posedge clk) begin
		if (pix_fire && push && !full) begin
			tab_s_q[cnt_q[IDX_W-1:0]] <= push_s;
			tab_e_q[cnt_q[IDX_W-1:0]] <= push_e;
		end
		if (pix_fire && wrapj) begin
			tab_s_q[0] <= rs_eff;
			tab_e_q[0] <= tab_e_q[0] + {1'b0, col_q} + 1'b1;
		end
		if (q_fire) begin
			qs_q <= ks;
			qe_q <= ke;
			qc_q <= kc;
			qw_q <= kw;
		end
		if (state_q == S_WAIT && lv[MAX_SEGMENTS]) found_q <= lid[MAX_SEGMENTS];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit || empty_emit) begin
			ov_q <= 1'b1;
		end else if (seg.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			osv_q   <= 1'b1;
			os_q    <= qs_q;
			oe_q    <= qe_q;
			oc_q    <= qc_q;
			ow_q    <= qw_q;
			oid_q   <= id_sel;
			oovf_q  <= ovf_q;
			olast_q <= is_last;
		end else if (empty_emit) begin
			osv_q   <= 1'b0;
			os_q    <= '0;
			oe_q    <= '0;
			oc_q    <= '0;
			ow_q    <= '0;
			oid_q   <= '0;
			oovf_q  <= 1'b0;
			olast_q <= 1'b1;
		end
	end

	assign seg.valid         = ov_q;
	assign seg.segment_valid = osv_q;
	assign seg.seg_start     = os_q;
	assign seg.seg_end       = oe_q;
	assign seg.seg_center    = oc_q;
	assign seg.seg_width     = ow_q;
	assign seg.track_id      = oid_q;
	assign seg.overflow      = oovf_q;
	assign seg.last_of_row   = olast_q;

	// Match chain
	assign lv[0]  = q_fire;
	assign lc[0]  = kc;
	assign lw[0]  = kw;
	assign lid[0] = '0;

	for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
		rst_cell #(
			.COL_W   (COL_W),
			.ID_BITS (ID_BITS),
			.CNT_W   (CNT_W),
			.IDX_W   (IDX_W),
			.IDX     (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tol       (tol_q),
			.old_count (old_cnt_q),
			.wr_en     (emit),
			.wr_idx    (k_q),
			.wr_id     (id_sel),
			.wr_c      (qc_q),
			.wr_w      (qw_q),
			.commit    (commit),
			.lv_i      (lv[g]),
			.lc_i      (lc[g]),
			.lw_i      (lw[g]),
			.lid_i     (lid[g]),
			.lv_o      (lv[g+1]),
			.lc_o      (lc[g+1]),
			.lw_o      (lw[g+1]),
			.lid_o     (lid[g+1])
		);
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_SEGMENTS))
		else $error("run count beyond capacity");
	a_commit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT |=> cnt_q == '0 && !ovf_q)
		else $error("row state not cleared after commit");
	a_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		lv[MAX_SEGMENTS] |-> state_q == S_WAIT)
		else $error("match result arrived outside wait");
	a_no_pix_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_PIX |-> !pix.ready)
		else $error("pixel taken while matching");
`endif

endmodule

@@ verif/tb_binary_row_segment_tracker.sv @@
`timescale 1ns / 100ps

module tb_binary_row_segment_tracker;
	import rst_pkg::*;

	localparam int ROW_MAX = 1024;
	localparam int SEG_MAX = 16;
	localparam int ID_TOP  = 65535;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic        px;
		logic        last;
	} pixel_t;

	typedef struct packed {
		logic        segment_valid;
		logic [9:0]  seg_start;
		logic [10:0] seg_end;
		logic [10:0] seg_center;
		logic [10:0] seg_width;
		logic [15:0] track_id;
		logic        overflow;
		logic        last_of_row;
	} segment_t;

	logic clk;
	logic arst_n;

	rst_pix_if pix ();
	rst_seg_if #(.COL_W(10), .ID_BITS(16)) seg ();
	rst_cfg_if cfg ();

	binary_row_segment_tracker #(
		.ROW_PIXELS_MAX(ROW_MAX),
		.MAX_SEGMENTS(SEG_MAX),
		.ID_BITS(16)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix.sink),
		.seg(seg.source),
		.cfg(cfg.sink)
	);

	pixel_t   pixel_queue[$];
	segment_t segment_queue[$];
	int       send_idle_pct;
	int       recv_stall_pct;
	int       hold_cycles;
	bit       pix_fired;
	int       mismatches;
	int       pixels_sent;
	int       segments_seen;
	int       rows_seen;

	// tracker shadow state
	bit       wrap_on;
	int       center_tol;
	int       width_tol;
	int       column;
	bit       last_px;
	int       open_start;
	int       run_cnt;
	int       run_lo[SEG_MAX];
	int       run_hi[SEG_MAX];
	int       prev_id[SEG_MAX];
	int       prev_center[SEG_MAX];
	int       prev_width[SEG_MAX];
	int       prev_cnt;
	int       top_id;
	bit       dropped;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// run limit
	initial begin
		#200ms;
		$display("status: fail");
		$finish;
	end

	function automatic void add_run(int s, int e);
		if (run_cnt < SEG_MAX) begin
			run_lo[run_cnt] = s;
			run_hi[run_cnt] = e;
			run_cnt++;
		end else begin
			dropped = 1'b1;
		end
	endfunction

	// track one accepted pixel and queue the segments a row end yields
	function automatic void track_pixel(bit px, bit last);
		int       nid[SEG_MAX];
		int       nc[SEG_MAX];
		int       nw[SEG_MAX];
		int       s;
		int       e;
		int       w;
		int       c;
		int       id;
		segment_t r;
		if (px != last_px) begin
			if (!px) add_run(open_start, column - 1);
			else open_start = column;
		end
		last_px = px;
		if (!last && column < ROW_MAX - 1) begin
			column++;
			return;
		end
		if (last_px) begin
			if (wrap_on && run_cnt > 0 && run_lo[0] == 0) begin
				run_lo[0] = open_start;
				run_hi[0] += column + 1;
			end else begin
				add_run(open_start, column);
			end
		end
		rows_seen++;
		if (run_cnt == 0) begin
			r = '0;
			r.last_of_row = 1'b1;
			segment_queue = {segment_queue, r};
		end
		for (int k = 0; k < run_cnt; k++) begin
			s = run_lo[k];
			e = run_hi[k];
			w = e - s;
			c = (s + e) / 2;
			id = 0;
			for (int j = 0; j < prev_cnt; j++) begin
				if ((c > prev_center[j] ? c - prev_center[j] : prev_center[j] - c) < center_tol &&
					(w > prev_width[j] ? w - prev_width[j] : prev_width[j] - w) < width_tol)
					id = prev_id[j];
			end
			if (id == 0) begin
				top_id = (top_id >= ID_TOP) ? 1 : top_id + 1;
				id = top_id;
			end
			nid[k] = id;
			nc[k] = c;
			nw[k] = w;
			r.segment_valid = 1'b1;
			r.seg_start = s[9:0];
			r.seg_end = e[10:0];
			r.seg_center = c[10:0];
			r.seg_width = w[10:0];
			r.track_id = id[15:0];
			r.overflow = dropped;
			r.last_of_row = (k + 1 == run_cnt);
			segment_queue = {segment_queue, r};
		end
		for (int k = 0; k < run_cnt; k++) begin
			prev_id[k] = nid[k];
			prev_center[k] = nc[k];
			prev_width[k] = nw[k];
		end
		prev_cnt = run_cnt;
		column = 0;
		last_px = 1'b0;
		open_start = 0;
		run_cnt = 0;
		dropped = 1'b0;
	endfunction

	// pixel driver: accept at the rising edge, offer at the falling edge
	always @(posedge clk) begin
		if (arst_n && pix.valid && pix.ready) begin
			track_pixel(pix.pixel_on, pix.row_end);
			void'(pixel_queue.pop_front());
			pixels_sent++;
			pix_fired = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!(pix.valid && !pix_fired)) begin
			if (arst_n && pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				pix.valid <= 1'b1;
				pix.pixel_on <= pixel_queue[0].px;
				pix.row_end <= pixel_queue[0].last;
			end else begin
				pix.valid <= 1'b0;
			end
		end
		pix_fired = 1'b0;
	end

	// segment monitor: compare at the rising edge, pace ready at the falling edge
	always @(posedge clk) begin
		segment_t got;
		segment_t want;
		if (arst_n && seg.valid && seg.ready) begin
			got = '{seg.segment_valid, seg.seg_start, seg.seg_end, seg.seg_center,
				seg.seg_width, seg.track_id, seg.overflow, seg.last_of_row};
			segments_seen++;
			if (segment_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected segment %p", got);
			end else begin
				want = segment_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("segment mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			seg.ready <= 1'b0;
		end else begin
			seg.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// wait until every request is taken and every segment has come
	task automatic drain();
		while (pixel_queue.size() > 0 || pix.valid || segment_queue.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		forever begin
			@(posedge clk);
			if (cfg.ready) break;
		end
		case (idx)
			REG_WRAP_ENABLE: wrap_on = value[0];
			REG_CENTER_TOLERANCE: center_tol = value;
			REG_WIDTH_TOLERANCE: width_tol = value;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_regs(bit wrap, int ctol, int wtol);
		write_reg(REG_WRAP_ENABLE, {9'd0, wrap});
		write_reg(REG_CENTER_TOLERANCE, ctol[9:0]);
		write_reg(REG_WIDTH_TOLERANCE, wtol[9:0]);
	endtask

	// queue a row given as a bit string, leftmost pixel first
	task automatic push_row(string bits);
		pixel_t p;
		for (int i = 0; i < bits.len(); i++) begin
			p.px = (bits[i] == "1");
			p.last = (i == bits.len() - 1);
			pixel_queue = {pixel_queue, p};
		end
	endtask

	// queue a row built from random runs; a tenth of calls adds loose noise pixels
	task automatic push_random_row();
		pixel_t p;
		int len;
		int n;
		bit v;
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(6, 1);
			repeat (n) begin
				p.px = 1'($urandom_range(1));
				p.last = ($urandom_range(3) == 0);
				pixel_queue = {pixel_queue, p};
			end
			return;
		end
		len = ($urandom_range(7) == 0) ? $urandom_range(60, 30) : $urandom_range(24, 1);
		v = 1'($urandom_range(1));
		n = 0;
		while (n < len) begin
			for (int r = $urandom_range(6, 1); r > 0 && n < len; r--) begin
				p.px = v;
				p.last = (n == len - 1);
				pixel_queue = {pixel_queue, p};
				n++;
			end
			v = ~v;
		end
	endtask

	task automatic random_phase(int count);
		int target;
		target = pixels_sent + pixel_queue.size() + count;
		while (pixels_sent + pixel_queue.size() < target)
			push_random_row();
		drain();
	endtask

	initial begin
		pix.valid = 1'b0;
		pix.pixel_on = 1'b0;
		pix.row_end = 1'b0;
		seg.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_WRAP_ENABLE;
		cfg.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		pix_fired = 1'b0;
		mismatches = 0;
		pixels_sent = 0;
		segments_seen = 0;
		rows_seen = 0;
		wrap_on = 1'b0;
		center_tol = CENTER_TOL_RST;
		width_tol = WIDTH_TOL_RST;
		column = 0;
		last_px = 1'b0;
		open_start = 0;
		run_cnt = 0;
		prev_cnt = 0;
		top_id = 0;
		dropped = 1'b0;
		@(posedge arst_n);
		repeat (2) @(posedge clk);

		// directed: empty row, trailing run, matched ids, overflow, wrap
		push_row("00000000");
		push_row("11111111");
		push_row("01101110");
		push_row("01101110");
		push_row("1");
		push_row("0");
		push_row({20{"10"}});
		drain();
		set_regs(1'b1, 1023, 1023);
		write_reg(REG_UNUSED, 10'h3FF);
		push_row("1100111");
		push_row("1100111");
		push_row("0110011");
		drain();

		// random phases under several pacing and register settings
		set_regs(1'b0, 0, 0);
		random_phase(50);
		send_idle_pct = 61;
		set_regs(1'b1, 1023, 1023);
		random_phase(50);
		send_idle_pct = 0;
		recv_stall_pct = 61;
		set_regs(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023));
		random_phase(50);
		send_idle_pct = 6;
		recv_stall_pct = 6;
		set_regs(1'b1, $urandom_range(8), $urandom_range(4));
		random_phase(50);

		// back pressure: hold the output off while rows keep coming
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		hold_cycles = 600;
		repeat (2) push_row({16{"10"}});
		drain();

		set_regs(1'b0, 40, 10);
		random_phase(20);

		$display("ran %0d pixels in %0d rows, %0d segments checked, ids to %0d",
			pixels_sent, rows_seen, segments_seen, top_id);
		$display("covered wrap, overflow, empty rows, an unused register and back pressure");
		if (mismatches == 0 && segment_queue.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d segments missing", mismatches, segment_queue.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/rst_pkg.sv
src/rst_if.sv
src/rst_cell.sv
src/binary_row_segment_tracker.sv
verif/tb_binary_row_segment_tracker.sv
